// ===== hdl/region_transfer_byte_counter_core_assert.svh =====
// assertion macros for the region transfer byte counter
`ifndef REGION_TRANSFER_BYTE_COUNTER_CORE_ASSERT_SVH
`define REGION_TRANSFER_BYTE_COUNTER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property that must hold in the same cycle
`define RTBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rtbc assertion failed");

// condition that must hold in the cycle after a trigger
`define RTBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rtbc assertion failed");

`else

`define RTBC_ASSERT(lbl, prop)
`define RTBC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/rtbc_pkg.sv =====
// types and codes shared by the region transfer byte counter
package rtbc_pkg;

  // operation codes
  localparam logic [1:0] FN_CLEAR = 2'd0;
  localparam logic [1:0] FN_ADD   = 2'd1;
  localparam logic [1:0] FN_LOG   = 2'd2;
  localparam logic [1:0] FN_READ  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;
  localparam logic [1:0] ST_NOINDEX = 2'd3;

  // width of a scaled region start
  localparam int unsigned ProdBits = 45;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  region_number;
    logic [31:0] region_start_sector;
    logic [39:0] byte_address;
    logic [12:0] block_size;
    logic [23:0] byte_count;
    logic        is_write;
    logic [3:0]  entry_index;
  } rtbc_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [7:0]  out_region_number;
    logic [31:0] out_start_sector;
    logic [47:0] written_total;
    logic [47:0] read_total;
    logic [4:0]  entries_in_use;
  } rtbc_out_t;

endpackage

// ===== hdl/rtbc_scale_match.sv =====
// shared scale-and-compare unit: start sector times block size against byte address
module rtbc_scale_match
  import rtbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [31:0] start_sector_i,
  input  logic [12:0] block_size_i,
  input  logic [39:0] byte_address_i,
  output logic        match_o
);

  logic [ProdBits-1:0] prod_q;
  logic [ProdBits-1:0] prod_d;

  // product is registered before the compare
  assign prod_d = ProdBits'(start_sector_i) * ProdBits'(block_size_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  // region start lies at or below the address
  assign match_o = (prod_q <= ProdBits'(byte_address_i));

endmodule

// ===== hdl/region_transfer_byte_counter_core.sv =====
// region transfer byte counter: region table, scan sequencer and result register
//
// Input channel in_valid_i / in_stall_o carries one request beat (rtbc_in_t);
// output channel out_valid_o / out_stall_i carries one result beat (rtbc_out_t).
// Every request gives exactly one result, in order.
// Clear and add: the result is formed on the request beat, then S_DONE hands it
// to the output register. Read entry: S_RDOUT, for the registered table read, comes before S_DONE.
// Log transfer: the table is walked from the newest region back, each slot
// taking S_MUL (multiply), then S_CMP (compare) through the one scale-and-compare
// unit; a match adds S_UPD to update the counter before S_DONE hands over the
// result; when no region matches, the walk goes straight to S_DONE.
// The next request is taken once the result is loaded into the output
// register, so a result waiting on the receiver does not block one request.
// If the receiver stalls, the result beat holds and the block holds the
// following result and stalls its input until the output register frees.
// Reset empties the table (entry count to zero) and clears the output valid;
// table contents need no clearing since only slots below the count are read.
// Counters saturate at 2^COUNTER_BITS - 1.
module region_transfer_byte_counter_core
  import rtbc_pkg::*;
#(
  parameter int unsigned MAX_REGIONS  = 16,
  parameter int unsigned COUNTER_BITS = 48
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rtbc_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rtbc_out_t out_data_o
);

`include "region_transfer_byte_counter_core_assert.svh"

  localparam int unsigned IW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned UCW = $clog2(MAX_REGIONS + 1);

  typedef struct packed {
    logic [7:0]              label;
    logic [31:0]             start;
    logic [COUNTER_BITS-1:0] wctr;
    logic [COUNTER_BITS-1:0] rctr;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CMP,
    S_UPD,
    S_RDOUT,
    S_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [UCW-1:0]  used_q, used_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [39:0]     addr_q, addr_d;
  logic [12:0]     bsize_q, bsize_d;
  logic [23:0]     cnt_q, cnt_d;
  logic            wr_q, wr_d;
  rtbc_out_t       res_q, res_d;
  rtbc_out_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;

  entry_t          mem [MAX_REGIONS];
  entry_t          rd_data_q;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  entry_t          mem_wdata;
  entry_t          upd_entry;

  logic            mul_load;
  logic            match;

  // saturating counter add
  function automatic logic [COUNTER_BITS-1:0] sat_add(
    input logic [COUNTER_BITS-1:0] ctr,
    input logic [23:0]             cnt
  );
    logic [COUNTER_BITS:0] sum;
    sum = {1'b0, ctr} + (COUNTER_BITS + 1)'(cnt);
    if (sum[COUNTER_BITS]) begin
      return '1;
    end
    return sum[COUNTER_BITS-1:0];
  endfunction

  // result beat describing one slot
  function automatic rtbc_out_t slot_result(
    input entry_t         e,
    input logic [IW-1:0]  s,
    input logic [UCW-1:0] n
  );
    rtbc_out_t r;
    r                   = '0;
    r.status            = ST_OK;
    r.slot              = 4'(s);
    r.out_region_number = e.label;
    r.out_start_sector  = e.start;
    r.written_total     = 48'(e.wctr);
    r.read_total        = 48'(e.rctr);
    r.entries_in_use    = 5'(n);
    return r;
  endfunction

  // shared scale-and-compare unit
  rtbc_scale_match u_match (
    .clk_i          (clk_i),
    .load_i         (mul_load),
    .start_sector_i (rd_data_q.start),
    .block_size_i   (bsize_q),
    .byte_address_i (addr_q),
    .match_o        (match)
  );

  // counter update of the matched slot
  always_comb begin
    upd_entry = rd_data_q;
    if (wr_q) begin
      upd_entry.wctr = sat_add(rd_data_q.wctr, cnt_q);
    end else begin
      upd_entry.rctr = sat_add(rd_data_q.rctr, cnt_q);
    end
  end

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    idx_d       = idx_q;
    addr_d      = addr_q;
    bsize_d     = bsize_q;
    cnt_d       = cnt_q;
    wr_d        = wr_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '0;
    mul_load    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          addr_d               = in_data_i.byte_address;
          bsize_d              = in_data_i.block_size;
          cnt_d                = in_data_i.byte_count;
          wr_d                 = in_data_i.is_write;
          res_d                = '0;
          res_d.entries_in_use = 5'(used_q);
          state_d              = S_DONE;
          case (in_data_i.func)
            FN_CLEAR: begin
              used_d               = '0;
              res_d.entries_in_use = '0;
            end
            FN_ADD: begin
              if (used_q == UCW'(MAX_REGIONS)) begin
                res_d.status = ST_FULL;
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = IW'(used_q);
                mem_wdata.label = in_data_i.region_number;
                mem_wdata.start = in_data_i.region_start_sector;
                used_d          = used_q + 1'b1;
                res_d           = slot_result(mem_wdata, IW'(used_q), used_d);
              end
            end
            FN_LOG: begin
              if (used_q == '0) begin
                res_d.status = ST_NOMATCH;
              end else begin
                idx_d   = IW'(used_q - 1'b1);
                state_d = S_MUL;
              end
            end
            default: begin
              if (9'(in_data_i.entry_index) < 9'(used_q)) begin
                idx_d   = IW'(in_data_i.entry_index);
                state_d = S_RDOUT;
              end else begin
                res_d.status = ST_NOINDEX;
              end
            end
          endcase
        end
      end

      // scale the start sector of the current slot
      S_MUL: begin
        mul_load = 1'b1;
        state_d  = S_CMP;
      end

      // compare, then step back to the next older slot or end with no match at the oldest
      S_CMP: begin
        if (match) begin
          state_d = S_UPD;
        end else if (idx_q == '0) begin
          res_d.status = ST_NOMATCH;
          state_d      = S_DONE;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = S_MUL;
        end
      end

      // write back the updated counter
      S_UPD: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = upd_entry;
        res_d     = slot_result(upd_entry, idx_q, used_q);
        state_d   = S_DONE;
      end

      S_RDOUT: begin
        res_d   = slot_result(rd_data_q, idx_q, used_q);
        state_d = S_DONE;
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // sequencer state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    addr_q  <= addr_d;
    bsize_q <= bsize_d;
    cnt_q   <= cnt_d;
    wr_q    <= wr_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  // region table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[idx_d];
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RTBC_ASSERT(a_used_bound, used_q <= UCW'(MAX_REGIONS))
  `RTBC_ASSERT(a_upd_in_use, (state_q != S_UPD) || (UCW'(idx_q) < used_q))
  `RTBC_ASSERT(a_out_from_done, !$rose(out_valid_q) || ($past(state_q) == S_DONE))
  `RTBC_ASSERT_NEXT(a_clear_empties,
    in_valid_i && !in_stall_o && (in_data_i.func == FN_CLEAR), used_q == '0)

endmodule

// ===== test/tb_region_transfer_byte_counter_core.sv =====
// testbench for the region transfer byte counter: request driver, predictor and result checker
module tb_region_transfer_byte_counter_core;
  import rtbc_pkg::*;

  localparam int unsigned MaxRegions = 16;
  localparam int unsigned RandPerPhase = 465;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 40;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  rtbc_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  rtbc_out_t out_data;

  // request beats waiting to be sent and result beats still owed by the block
  rtbc_in_t  req_backlog[$];
  rtbc_out_t slot_reports_due[$];
  rtbc_out_t want;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  // predicted region table
  logic [4:0]  tbl_used;
  logic [7:0]  tbl_label[MaxRegions];
  logic [31:0] tbl_start[MaxRegions];
  logic [47:0] tbl_wr[MaxRegions];
  logic [47:0] tbl_rd[MaxRegions];

  // region starts as seen when the stimulus is built, used to aim log addresses
  int unsigned gen_used = 0;
  logic [31:0] gen_start[MaxRegions];

  region_transfer_byte_counter_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    tbl_used = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // apply one request to the predicted table and return the result it gives
  function automatic rtbc_out_t table_apply(rtbc_in_t req);
    rtbc_out_t   res;
    logic [44:0] scaled;
    logic [48:0] sum;
    int          hit;
    res = '0;
    hit = -1;
    case (req.func)
      FN_CLEAR: begin
        tbl_used = '0;
      end
      FN_ADD: begin
        if (tbl_used >= MaxRegions) begin
          res.status = ST_FULL;
        end else begin
          tbl_label[4'(tbl_used)] = req.region_number;
          tbl_start[4'(tbl_used)] = req.region_start_sector;
          tbl_wr[4'(tbl_used)] = '0;
          tbl_rd[4'(tbl_used)] = '0;
          hit = int'(tbl_used);
          tbl_used = tbl_used + 5'd1;
        end
      end
      FN_LOG: begin
        // newest region first, full-width scaled start
        for (int i = int'(tbl_used) - 1; i >= 0 && hit < 0; i--) begin
          scaled = 45'(tbl_start[4'(i)]) * 45'(req.block_size);
          if (scaled <= 45'(req.byte_address)) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_NOMATCH;
        end else if (req.is_write) begin
          sum = {1'b0, tbl_wr[4'(hit)]} + 49'(req.byte_count);
          tbl_wr[4'(hit)] = sum[48] ? '1 : sum[47:0];
        end else begin
          sum = {1'b0, tbl_rd[4'(hit)]} + 49'(req.byte_count);
          tbl_rd[4'(hit)] = sum[48] ? '1 : sum[47:0];
        end
      end
      default: begin
        if (5'(req.entry_index) < tbl_used) hit = int'(req.entry_index);
        else res.status = ST_NOINDEX;
      end
    endcase
    if (hit >= 0) begin
      res.slot = 4'(hit);
      res.out_region_number = tbl_label[4'(hit)];
      res.out_start_sector = tbl_start[4'(hit)];
      res.written_total = tbl_wr[4'(hit)];
      res.read_total = tbl_rd[4'(hit)];
    end
    res.entries_in_use = tbl_used;
    return res;
  endfunction

  // request beat sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) slot_reports_due.push_back(table_apply(in_data));
      if (!in_valid || !in_stall) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= req_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result beat receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic check_field(string name, logic [47:0] exp_val, logic [47:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      mismatch_cnt++;
    end
  endtask

  // result beat checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (slot_reports_due.size() == 0) begin
        $display("%0t: result beat with none expected, actual %p", $time, out_data);
        mismatch_cnt++;
      end else begin
        want = slot_reports_due.pop_front();
        check_field("status", 48'(want.status), 48'(out_data.status));
        check_field("slot", 48'(want.slot), 48'(out_data.slot));
        check_field("out_region_number", 48'(want.out_region_number),
                    48'(out_data.out_region_number));
        check_field("out_start_sector", 48'(want.out_start_sector),
                    48'(out_data.out_start_sector));
        check_field("written_total", want.written_total, out_data.written_total);
        check_field("read_total", want.read_total, out_data.read_total);
        check_field("entries_in_use", 48'(want.entries_in_use), 48'(out_data.entries_in_use));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // request with every field random
  function automatic rtbc_in_t noise_req();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return bits[123:0];
  endfunction

  task automatic queue_req(rtbc_in_t req);
    if (req.func == FN_CLEAR) begin
      gen_used = 0;
    end else if (req.func == FN_ADD && gen_used < MaxRegions) begin
      gen_start[4'(gen_used)] = req.region_start_sector;
      gen_used++;
    end
    req_backlog.push_back(req);
  endtask

  // random request, mostly well-formed table traffic with aimed log addresses
  function automatic rtbc_in_t random_req();
    rtbc_in_t    req;
    int unsigned pick;
    int unsigned j;
    logic [44:0] aim;
    req = noise_req();
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      req.func = FN_CLEAR;
    end else if (pick < 28) begin
      req.func = FN_ADD;
      case ($urandom_range(0, 3))
        0, 1: req.region_start_sector = 32'($urandom_range(0, 1 << 20));
        2: req.region_start_sector = $urandom;
        default: req.region_start_sector = 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
      endcase
    end else if (pick < 75) begin
      req.func = FN_LOG;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: req.block_size = 13'(1 << $urandom_range(0, 12));
        6, 7: req.block_size = 13'($urandom_range(0, 8191));
        8: req.block_size = '0;
        default: req.block_size = '1;
      endcase
      case ($urandom_range(0, 7))
        0: req.byte_count = '1;
        1: req.byte_count = '0;
        default: ;
      endcase
      if (gen_used > 0 && $urandom_range(0, 99) < 65) begin
        j = $urandom_range(0, gen_used - 1);
        aim = 45'(gen_start[4'(j)]) * 45'(req.block_size);
        case ($urandom_range(0, 3))
          0: ;
          1: if (aim != 0) aim = aim - 45'd1;
          2: aim = aim + 45'd1;
          default: aim = aim + 45'($urandom_range(0, 4095));
        endcase
        if (aim[44:40] == '0) req.byte_address = aim[39:0];
      end
    end else begin
      req.func = FN_READ;
    end
    return req;
  endfunction

  task automatic wait_drained();
    while (req_backlog.size() != 0 || in_valid || slot_reports_due.size() != 0) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  // stimulus phases
  initial begin
    rtbc_in_t req;
    int       k;
    @(posedge rst_ni);
    @(negedge clk_i);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      if (ph == 0) begin
        // empty table: log finds nothing, read finds no entry
        req = noise_req(); req.func = FN_LOG; queue_req(req);
        req = noise_req(); req.func = FN_READ; req.entry_index = '0; queue_req(req);
        // extreme labels and starts
        req = noise_req(); req.func = FN_ADD;
        req.region_number = '0; req.region_start_sector = '0; queue_req(req);
        req = noise_req(); req.func = FN_ADD;
        req.region_number = '1; req.region_start_sector = '1; queue_req(req);
        // largest write into the newest region
        req = noise_req(); req.func = FN_LOG; req.byte_address = '1;
        req.block_size = 13'd1; req.byte_count = '1; req.is_write = 1'b1; queue_req(req);
        // huge scaled start skips the newest region
        req = noise_req(); req.func = FN_LOG; req.byte_address = '0;
        req.block_size = '1; req.byte_count = '1; req.is_write = 1'b0; queue_req(req);
        // zero block size always hits the newest region
        req = noise_req(); req.func = FN_LOG; req.byte_address = '0;
        req.block_size = '0; req.is_write = 1'b0; queue_req(req);
        req = noise_req(); req.func = FN_CLEAR; queue_req(req);
        // fill the table, then add once more
        for (k = 0; k < MaxRegions; k++) begin
          req = noise_req(); req.func = FN_ADD;
          req.region_number = 8'(k * 17); req.region_start_sector = 32'(k) << 28;
          queue_req(req);
        end
        req = noise_req(); req.func = FN_ADD; queue_req(req);
        req = noise_req(); req.func = FN_READ; req.entry_index = '1; queue_req(req);
        // only the oldest region matches, full table walk
        req = noise_req(); req.func = FN_LOG; req.byte_address = 40'h00_FFFF_FFFF;
        req.block_size = 13'd4096; queue_req(req);
      end
      repeat (RandPerPhase) queue_req(random_req());
      // stimulus waits until every queued request is sent and every owed result has arrived
      wait_drained();
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== region_transfer_byte_counter_core.f =====
+incdir+hdl
hdl/rtbc_pkg.sv
hdl/rtbc_scale_match.sv
hdl/region_transfer_byte_counter_core.sv
test/tb_region_transfer_byte_counter_core.sv
